/* rtl/core/rtcf_pkg.sv */
`timescale 1ns / 1ps

package rtcf_pkg;

  // default width of the elapsed time and fade length counters
  localparam int unsigned TimeBitsDefault = 24;

  localparam int unsigned ColourW   = 8;
  localparam int unsigned NumChan   = 4;
  localparam int unsigned ChanIdxW  = $clog2(NumChan);
  localparam int unsigned DurationW = 24;
  localparam int unsigned FrameW    = 16;

  // quotient bits produced by the divider, one per cycle
  localparam int unsigned QuotBits  = ColourW;
  localparam int unsigned QuotCntW  = $clog2(QuotBits);

  localparam logic [ColourW-1:0] TintReset = {ColourW{1'b1}};

  typedef enum logic {
    OpTick  = 1'b0,
    OpFlash = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StMulSrc,
    StMulGoal,
    StDiv,
    StResp
  } fade_state_e;

  typedef logic [ColourW-1:0] colour_t;

endpackage

/* rtl/core/rgba_timed_color_fade.sv */
`timescale 1ns / 1ps

// flash, tick that ends a fade, or tick while no fade runs: word offered in the cycle after accept
// tick during a fade: prep, then per channel multiply source, multiply goal and divide, set by one shared
//   multiplier and one restoring divider walked channel by channel
// one word in flight: no new word is taken until the result has been taken
// reset (async, rst_ni low): tint white opaque, no fade running, source and goal zero
module rgba_timed_color_fade #(
  parameter int unsigned TIME_BITS = rtcf_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [rtcf_pkg::FrameW-1:0]    frame_time_i,
  input  logic [rtcf_pkg::DurationW-1:0] duration_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_red_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_green_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_blue_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_alpha_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rtcf_pkg::ColourW-1:0]   tint_red_o,
  output logic [rtcf_pkg::ColourW-1:0]   tint_green_o,
  output logic [rtcf_pkg::ColourW-1:0]   tint_blue_o,
  output logic [rtcf_pkg::ColourW-1:0]   tint_alpha_o,
  output logic                           fading_o
);
  import rtcf_pkg::*;

  // accumulator holds the blend sum, which stays below 256 * fade length
  localparam int unsigned AccW = TIME_BITS + ColourW;
  // elapsed plus frame time, one bit of headroom
  localparam int unsigned SumW = ((TIME_BITS > FrameW) ? TIME_BITS : FrameW) + 1;

  fade_state_e state_q, state_d;

  // architectural state
  colour_t              tint_q   [NumChan];
  colour_t              src_q    [NumChan];
  colour_t              goal_q   [NumChan];
  logic [TIME_BITS-1:0] elap_q;
  logic [TIME_BITS-1:0] len_q;

  // working registers of the shared datapath
  logic [TIME_BITS-1:0] diff_q;
  logic [AccW-1:0]      acc_q;
  logic [ChanIdxW-1:0]  ch_q;
  logic [QuotCntW-1:0]  cnt_q;

  logic                 in_fire;
  logic                 out_fire;
  logic [TIME_BITS-1:0] dur_kept;
  logic [SumW-1:0]      tick_sum;
  logic                 tick_done;
  logic [TIME_BITS-1:0] tick_elap;

  colour_t              mul_a;
  logic [TIME_BITS-1:0] mul_b;
  logic [AccW-1:0]      prod;

  logic [TIME_BITS:0]   div_t;
  logic                 div_ge;
  logic [TIME_BITS:0]   div_r;
  logic [AccW-1:0]      acc_div;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // only the low TIME_BITS bits of the duration are kept
  assign dur_kept = TIME_BITS'(duration_i);

  // tick: add frame time and saturate at the fade length
  assign tick_sum  = SumW'(elap_q) + SumW'(frame_time_i);
  assign tick_done = (tick_sum >= SumW'(len_q));
  assign tick_elap = tick_done ? len_q : tick_sum[TIME_BITS-1:0];

  // shared multiplier: src * (D - e) first, then goal * e
  assign mul_a = (state_q == StMulSrc) ? src_q[ch_q] : goal_q[ch_q];
  assign mul_b = (state_q == StMulSrc) ? diff_q : elap_q;
  assign prod  = AccW'(mul_a) * AccW'(mul_b);

  // restoring divide step, remainder in the top bits, quotient shifts in below
  assign div_t   = acc_q[AccW-1:QuotBits-1];
  assign div_ge  = (div_t >= {1'b0, len_q});
  assign div_r   = div_ge ? (div_t - {1'b0, len_q}) : div_t;
  assign acc_div = {div_r[TIME_BITS-1:0], acc_q[QuotBits-2:0], div_ge};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (op_i == OpFlash || len_q == '0 || tick_done) begin
            state_d = StResp;
          end else begin
            state_d = StPrep;
          end
        end
      end
      StPrep:    state_d = StMulSrc;
      StMulSrc:  state_d = StMulGoal;
      StMulGoal: state_d = StDiv;
      StDiv: begin
        if (cnt_q == QuotCntW'(QuotBits - 1)) begin
          state_d = (ch_q == ChanIdxW'(NumChan - 1)) ? StResp : StMulSrc;
        end
      end
      StResp: begin
        if (out_fire) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle:  in_ready_o  = 1'b1;
      StResp:  out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath and fade state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        tint_q[c] <= TintReset;
        src_q[c]  <= '0;
        goal_q[c] <= '0;
      end
      elap_q <= '0;
      len_q  <= '0;
      ch_q   <= '0;
      cnt_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (op_i == OpFlash) begin
              for (int c = 0; c < NumChan; c++) begin
                src_q[c] <= tint_q[c];
              end
              goal_q[0] <= target_red_i;
              goal_q[1] <= target_green_i;
              goal_q[2] <= target_blue_i;
              goal_q[3] <= target_alpha_i;
              elap_q    <= '0;
              len_q     <= dur_kept;
            end else if (len_q != '0) begin
              elap_q <= tick_elap;
              if (tick_done) begin
                // fade reached its end: snap to the goal
                for (int c = 0; c < NumChan; c++) begin
                  tint_q[c] <= goal_q[c];
                end
                len_q <= '0;
              end
            end
          end
        end
        StPrep: begin
          ch_q <= '0;
        end
        StMulGoal: begin
          cnt_q <= '0;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == QuotCntW'(QuotBits - 1)) begin
            tint_q[ch_q] <= acc_div[ColourW-1:0];
            ch_q         <= ch_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StPrep:    diff_q <= len_q - elap_q;
      StMulSrc:  acc_q  <= prod;
      StMulGoal: acc_q  <= acc_q + prod;
      StDiv:     acc_q  <= acc_div;
      default: begin
      end
    endcase
  end

  assign tint_red_o   = tint_q[0];
  assign tint_green_o = tint_q[1];
  assign tint_blue_o  = tint_q[2];
  assign tint_alpha_o = tint_q[3];
  assign fading_o     = (len_q != '0);

  // never offering and taking a word at the same time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshake both open");

  // a running fade, when its blended result is offered, has elapsed time short of its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fading_o && state_q == StResp && $past(state_q) != StResp
     && $past(state_q) != StIdle) |-> (elap_q < len_q))
    else $error("fade still running with elapsed time at its length");

  // a flash answers on the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == OpFlash) |=> out_valid_o)
    else $error("flash did not answer at once");

  // the divider always finishes a channel before the multiplier starts again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMulSrc && $past(state_q) == StDiv)
      |-> ($past(cnt_q) == QuotCntW'(QuotBits - 1)))
    else $error("channel left before all quotient bits were made");

endmodule

/* tb/tint_fade_checker.sv */
`timescale 1ns / 1ps

module tint_fade_checker #(
  parameter int unsigned TIME_BITS = rtcf_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           op_i,
  input  logic [rtcf_pkg::FrameW-1:0]    frame_time_i,
  input  logic [rtcf_pkg::DurationW-1:0] duration_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_red_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_green_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_blue_i,
  input  logic [rtcf_pkg::ColourW-1:0]   target_alpha_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [rtcf_pkg::ColourW-1:0]   tint_red_i,
  input  logic [rtcf_pkg::ColourW-1:0]   tint_green_i,
  input  logic [rtcf_pkg::ColourW-1:0]   tint_blue_i,
  input  logic [rtcf_pkg::ColourW-1:0]   tint_alpha_i,
  input  logic                           fading_i,
  output int                             mismatch_count_o,
  output int                             tint_words_due_o
);
  import rtcf_pkg::*;

  typedef struct packed {
    logic [NumChan-1:0][ColourW-1:0] chan;
    logic                            fading;
  } tint_word_t;

  string chan_name [NumChan] = '{"tint_red", "tint_green", "tint_blue", "tint_alpha"};

  // own copy of the fade state
  colour_t              tint_c [NumChan];
  colour_t              src_c  [NumChan];
  colour_t              goal_c [NumChan];
  logic [TIME_BITS-1:0] elapsed_t;
  logic [TIME_BITS-1:0] span_t;

  tint_word_t tint_due_q [$];
  tint_word_t want_w;
  tint_word_t got_w;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // advance the fade by one word and queue the tint it should return
  task automatic fold_word(input logic op, input logic [FrameW-1:0] ft,
                           input logic [DurationW-1:0] dur,
                           input logic [NumChan-1:0][ColourW-1:0] tgt);
    longint unsigned sum;
    longint unsigned d;
    longint unsigned e;
    longint unsigned mix;
    tint_word_t      w;
    int              c;
    if (op == OpFlash) begin
      for (c = 0; c < NumChan; c++) begin
        src_c[c]  = tint_c[c];
        goal_c[c] = tgt[c];
      end
      elapsed_t = '0;
      span_t    = TIME_BITS'(dur);
    end else if (span_t != '0) begin
      sum = longint'(elapsed_t) + longint'(ft);
      if (sum > longint'(span_t)) sum = longint'(span_t);
      elapsed_t = TIME_BITS'(sum);
      if (elapsed_t >= span_t) begin
        for (c = 0; c < NumChan; c++) tint_c[c] = goal_c[c];
        span_t = '0;
      end else begin
        d = longint'(span_t);
        e = longint'(elapsed_t);
        for (c = 0; c < NumChan; c++) begin
          mix = longint'(src_c[c]) * (d - e) + longint'(goal_c[c]) * e;
          tint_c[c] = colour_t'(mix / d);
        end
      end
    end
    for (c = 0; c < NumChan; c++) w.chan[c] = tint_c[c];
    w.fading = (span_t != '0);
    tint_due_q.push_back(w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        tint_c[c] = TintReset;
        src_c[c]  = '0;
        goal_c[c] = '0;
      end
      elapsed_t = '0;
      span_t    = '0;
      tint_due_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tint_due_q.size() == 0) begin
          report_mismatch("word with nothing due", 0, 0);
        end else begin
          want_w = tint_due_q.pop_front();
          got_w.chan   = {tint_alpha_i, tint_blue_i, tint_green_i, tint_red_i};
          got_w.fading = fading_i;
          for (int c = 0; c < NumChan; c++) begin
            if (got_w.chan[c] !== want_w.chan[c])
              report_mismatch(chan_name[c], got_w.chan[c], want_w.chan[c]);
          end
          if (got_w.fading !== want_w.fading)
            report_mismatch("fading", got_w.fading, want_w.fading);
        end
      end
      if (in_valid_i && in_ready_i)
        fold_word(op_i, frame_time_i, duration_i,
                  {target_alpha_i, target_blue_i, target_green_i, target_red_i});
    end
    tint_words_due_o = tint_due_q.size();
  end

endmodule

/* tb/rgba_timed_color_fade_tb.sv */
`timescale 1ns / 1ps

module rgba_timed_color_fade_tb;
  import rtcf_pkg::*;

  // random part stops after about this many words
  localparam int RandWords = 1850;
  // settle time after the last result, well above the longest fade step
  localparam int DrainCycles = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic [FrameW-1:0]    frame_time;
  logic [DurationW-1:0] duration;
  logic [ColourW-1:0]   target_red;
  logic [ColourW-1:0]   target_green;
  logic [ColourW-1:0]   target_blue;
  logic [ColourW-1:0]   target_alpha;
  logic                 out_valid;
  logic                 out_ready;
  logic [ColourW-1:0]   tint_red;
  logic [ColourW-1:0]   tint_green;
  logic [ColourW-1:0]   tint_blue;
  logic [ColourW-1:0]   tint_alpha;
  logic                 fading;

  int mismatch_count;
  int tint_words_due;
  int words_sent;
  // when set, neither side idles, giving back-to-back stretches
  bit calm;

  rgba_timed_color_fade u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .frame_time_i   (frame_time),
    .duration_i     (duration),
    .target_red_i   (target_red),
    .target_green_i (target_green),
    .target_blue_i  (target_blue),
    .target_alpha_i (target_alpha),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .tint_red_o     (tint_red),
    .tint_green_o   (tint_green),
    .tint_blue_o    (tint_blue),
    .tint_alpha_o   (tint_alpha),
    .fading_o       (fading)
  );

  // watches both channels, predicts every tint and counts mismatches
  tint_fade_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (op),
    .frame_time_i     (frame_time),
    .duration_i       (duration),
    .target_red_i     (target_red),
    .target_green_i   (target_green),
    .target_blue_i    (target_blue),
    .target_alpha_i   (target_alpha),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .tint_red_i       (tint_red),
    .tint_green_i     (tint_green),
    .tint_blue_i      (tint_blue),
    .tint_alpha_i     (tint_alpha),
    .fading_i         (fading),
    .mismatch_count_o (mismatch_count),
    .tint_words_due_o (tint_words_due)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // frame time for a tick, scaled to the running fade length so fades finish
  function automatic logic [FrameW-1:0] pick_frame_time(input logic [DurationW-1:0] span);
    int r;
    int cap;
    r   = $urandom_range(0, 99);
    cap = (span / 6) + 1;
    if (cap > 65535) cap = 65535;
    if (r < 10) return '0;
    if (r < 65) return FrameW'($urandom_range(1, cap));
    if (r < 85) return FrameW'($urandom_range(0, 255));
    return FrameW'($urandom_range(0, 65535));
  endfunction

  // present one word, hold it until the block takes it; entered and left on a rising edge
  task automatic send_word(input op_e kind, input logic [FrameW-1:0] ft,
                           input logic [DurationW-1:0] dur, input logic [31:0] tgt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    frame_time   <= ft;
    duration     <= dur;
    target_red   <= tgt[7:0];
    target_green <= tgt[15:8];
    target_blue  <= tgt[23:16];
    target_alpha <= tgt[31:24];
    // ready is looked at mid-cycle, away from the edge where it changes
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // result side: ready with random stalls, independent of valid
  initial begin : drain_side
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int                   r;
    int                   n;
    int                   target_words;
    logic [DurationW-1:0] span;

    // every input known from time zero
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    op           = OpTick;
    frame_time   = '0;
    duration     = '0;
    target_red   = '0;
    target_green = '0;
    target_blue  = '0;
    target_alpha = '0;
    out_ready    = 1'b0;
    words_sent   = 0;
    calm         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks straight out of reset, nothing running: white opaque back
    send_word(OpTick, 16'h0000, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
    // flash of zero length: target stored, no fade, tint unchanged
    send_word(OpFlash, 16'hFFFF, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'h0040, 24'h000000, 32'h0000_0000);
    // short fade to black: zero-time tick, partial steps, then the end
    send_word(OpFlash, 16'h0000, 24'h000004, 32'h0000_0000);
    send_word(OpTick, 16'h0000, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'h0001, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'h0002, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'h0001, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'h0005, 24'h000000, 32'h0000_0000);
    // longest fade with widest ticks, then a flash in mid fade
    send_word(OpFlash, 16'h1234, 24'hFFFFFF, 32'h0180_00FF);
    send_word(OpTick, 16'hFFFF, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'hFFFF, 24'h000000, 32'h0000_0000);
    send_word(OpFlash, 16'h0000, 24'h000003, 32'h00FF_55AA);
    // overshoot saturates at the fade length
    send_word(OpTick, 16'hFFFF, 24'h000000, 32'h0000_0000);
    // unit length fade
    send_word(OpFlash, 16'h0000, 24'h000001, 32'hFFFF_FFFF);
    send_word(OpTick, 16'h0000, 24'h000000, 32'h0000_0000);
    send_word(OpTick, 16'h0001, 24'h000000, 32'h0000_0000);
    // top bit of the duration alone
    send_word(OpFlash, 16'h0000, 24'h800000, 32'h8040_2010);
    send_word(OpTick, 16'h8000, 24'h000000, 32'h0000_0000);
    send_word(OpFlash, 16'h0000, 24'h000000, 32'h0000_0000);

    target_words = words_sent + RandWords;
    while (words_sent < target_words) begin
      calm = ($urandom_range(0, 4) == 0);
      r    = $urandom_range(0, 99);
      if (r < 85) begin
        // well-formed fade: a flash, then a run of ticks
        r = $urandom_range(0, 99);
        if (r < 8) span = '0;
        else if (r < 50) span = DurationW'($urandom_range(1, 32));
        else if (r < 80) span = DurationW'($urandom_range(1, 2000));
        else if (r < 95) span = DurationW'($urandom_range(1, 200000));
        else span = DurationW'($urandom());
        send_word(OpFlash, FrameW'($urandom()), span, $urandom());
        n = $urandom_range(1, 14);
        repeat (n) send_word(OpTick, pick_frame_time(span), DurationW'($urandom()), $urandom());
      end else begin
        // noise: anything at all
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_word($urandom_range(0, 1) ? OpFlash : OpTick, FrameW'($urandom()),
                    DurationW'($urandom()), $urandom());
        end
      end
    end
    calm     = 1'b0;
    in_valid <= 1'b0;

    // wait for every predicted tint, then let the block settle
    @(negedge clk);
    while (tint_words_due != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rgba_timed_color_fade verification clean");
    end else begin
      $display("rgba_timed_color_fade verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #(4_000_000);
    $display("rgba_timed_color_fade verification failed");
    $finish;
  end

endmodule
